@@ rtl/qoid_pkg.sv @@
// Shared types, codes and helpers for the QOI stream decoder.
// No dependencies; used by qoid_front, qoid_fifo, qoid_back and the top level.
package qoid_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int TAB_AW        = $clog2(TABLE_ENTRIES);
    localparam int RUN_W         = 6;

    localparam logic [2:0] ST_PIXEL      = 3'd0;
    localparam logic [2:0] ST_DONE       = 3'd1;
    localparam logic [2:0] ST_ABRUPT     = 3'd2;
    localparam logic [2:0] ST_MAGIC      = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd4;
    localparam logic [2:0] ST_CHANNELS   = 3'd5;
    localparam logic [2:0] ST_COLORSPACE = 3'd6;
    localparam logic [2:0] ST_END_MARKER = 3'd7;

    localparam logic [7:0] OP_RGB    = 8'hFE;
    localparam logic [7:0] OP_RGBA   = 8'hFF;
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    localparam logic [31:0] MAX_PIXELS_RESET = 32'd400_000_000;
    localparam logic [31:0] PIXEL_START      = 32'h0000_00FF;

    // One queued result group: a pixel repeated count times, or a status
    typedef struct packed {
        logic [31:0]      pixel;
        logic [2:0]       status;
        logic [RUN_W-1:0] count;
        logic [31:0]      width;
        logic [31:0]      height;
    } t_cmd;

    function automatic logic [TAB_AW-1:0] px_hash(input logic [31:0] px);
        logic [11:0] s;
        s = 12'(px[31:24]) * 12'd3 + 12'(px[23:16]) * 12'd5
          + 12'(px[15:8]) * 12'd7 + 12'(px[7:0]) * 12'd11;
        return s[TAB_AW-1:0];
    endfunction

    function automatic logic [7:0] magic_byte(input logic [1:0] p);
        logic [7:0] m;
        case (p)
            2'd0:    m = 8'h71;
            2'd1:    m = 8'h6F;
            2'd2:    m = 8'h69;
            default: m = 8'h66;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/qoid_front.sv @@
// Byte parser: header check, chunk decode, seen table and end marker check.
// Depends on qoid_pkg; pushes result groups into the queue ahead of qoid_back.
module qoid_front import qoid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_ready,
    input  logic [31:0] i_max_pixels,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam logic [2:0] S_HDR   = 3'd0;
    localparam logic [2:0] S_CHUNK = 3'd1;
    localparam logic [2:0] S_OPER  = 3'd2;
    localparam logic [2:0] S_FOOT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_CHK   = 3'd6;
    localparam logic [2:0] S_IDX   = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_op, n_op;
    logic [31:0] r_w, n_w;
    logic [31:0] r_h, n_h;
    logic [31:0] r_left, n_left;
    logic [31:0] r_prev, n_prev;
    logic [63:0] r_prod;
    logic [TABLE_ENTRIES-1:0] r_tvalid;
    logic [31:0] r_mem [TABLE_ENTRIES];
    logic [31:0] r_rdata;
    logic        r_rvalid;

    logic              accept;
    logic              we;
    logic [TAB_AW-1:0] waddr;
    logic [TAB_AW-1:0] raddr;
    logic              tab_clear;
    logic              emit;
    logic [31:0]       px;
    logic              flag;
    logic [7:0]        b;
    logic [5:0]        v;
    logic [RUN_W-1:0]  run_n;
    logic [2:0]        need;
    logic [3:0]        pos_inc;
    logic [4:0]        shamt;

    assign b = i_data_byte;
    assign v = i_data_byte[5:0];
    assign o_ready = !i_full && (r_state == S_HDR || r_state == S_CHUNK ||
                     r_state == S_OPER || r_state == S_FOOT || r_state == S_FIN);
    assign accept = i_valid && o_ready;
    assign pos_inc = r_pos + 4'd1;

    always_comb begin
        n_state = r_state;
        n_pos = r_pos;
        n_op = r_op;
        n_w = r_w;
        n_h = r_h;
        n_left = r_left;
        n_prev = r_prev;
        o_push = 1'b0;
        o_cmd = '0;
        tab_clear = 1'b0;
        raddr = v;
        emit = 1'b0;
        px = r_prev;
        flag = 1'b0;
        run_n = '0;
        need = 3'd1;
        shamt = '0;

        if (accept && i_stream_end) begin
            if (r_state == S_FIN) begin
                n_state = S_HDR;
            end else begin
                o_push = 1'b1;
                o_cmd.status = ST_ABRUPT;
                o_cmd.count = RUN_W'(1);
                n_state = S_HDR;
            end
            n_pos = '0;
            n_op = '0;
        end else if (accept) begin
            case (r_state)
                S_HDR: begin
                    if (r_pos < 4'd4) begin
                        flag = (r_pos == 4'd0) ? 1'b0 : r_op[0];
                        if (b != magic_byte(r_pos[1:0])) flag = 1'b1;
                        if (r_pos == 4'd3 && flag) begin
                            o_push = 1'b1;
                            o_cmd.status = ST_MAGIC;
                            o_cmd.count = RUN_W'(1);
                            n_state = S_FIN;
                            n_pos = '0;
                            n_op = '0;
                        end else begin
                            n_op = {7'd0, flag};
                            n_pos = pos_inc;
                        end
                    end else if (r_pos < 4'd8) begin
                        n_w = {r_w[23:0], b};
                        n_pos = pos_inc;
                    end else if (r_pos < 4'd12) begin
                        n_h = {r_h[23:0], b};
                        n_pos = pos_inc;
                        // size check needs the product; the S_MUL and S_CHK states compute and compare it
                        if (r_pos == 4'd11) n_state = S_MUL;
                    end else if (r_pos == 4'd12) begin
                        if (b != 8'd3 && b != 8'd4) begin
                            o_push = 1'b1;
                            o_cmd.status = ST_CHANNELS;
                            o_cmd.count = RUN_W'(1);
                            n_state = S_FIN;
                            n_pos = '0;
                            n_op = '0;
                        end else begin
                            n_pos = pos_inc;
                        end
                    end else begin
                        if (b > 8'd1) begin
                            o_push = 1'b1;
                            o_cmd.status = ST_COLORSPACE;
                            o_cmd.count = RUN_W'(1);
                            n_state = S_FIN;
                        end else begin
                            n_prev = PIXEL_START;
                            tab_clear = 1'b1;
                            n_left = r_prod[31:0];
                            n_state = (r_prod[31:0] == 32'd0) ? S_FOOT : S_CHUNK;
                        end
                        n_pos = '0;
                        n_op = '0;
                    end
                end
                S_CHUNK: begin
                    if (b == OP_RGB || b == OP_RGBA || b[7:6] == TAG_LUMA) begin
                        n_op = b;
                        n_pos = '0;
                        n_state = S_OPER;
                    end else if (b[7:6] == TAG_INDEX) begin
                        n_state = S_IDX;
                    end else if (b[7:6] == TAG_DIFF) begin
                        emit = 1'b1;
                        px = {r_prev[31:24] + {6'd0, v[5:4]} + 8'd254,
                              r_prev[23:16] + {6'd0, v[3:2]} + 8'd254,
                              r_prev[15:8] + {6'd0, v[1:0]} + 8'd254,
                              r_prev[7:0]};
                    end else begin
                        run_n = v + RUN_W'(1);
                        if (r_left < 32'(run_n)) run_n = r_left[RUN_W-1:0];
                        o_push = 1'b1;
                        o_cmd.pixel = r_prev;
                        o_cmd.status = ST_PIXEL;
                        o_cmd.count = run_n;
                        n_left = r_left - 32'(run_n);
                        if (n_left == 32'd0) begin
                            n_state = S_FOOT;
                            n_pos = '0;
                            n_op = '0;
                        end
                    end
                end
                S_OPER: begin
                    n_pos = pos_inc;
                    if (r_op == OP_RGB || r_op == OP_RGBA) begin
                        need = (r_op == OP_RGB) ? 3'd3 : 3'd4;
                        shamt = 5'd24 - {r_pos[1:0], 3'd0};
                        px = (r_prev & ~(32'hFF << shamt)) | (32'(b) << shamt);
                        if (pos_inc >= 4'(need)) emit = 1'b1;
                        else n_prev = px;
                    end else begin
                        emit = 1'b1;
                        px = {r_prev[31:24] + {4'd0, b[7:4]} + {2'd0, r_op[5:0]} + 8'd216,
                              r_prev[23:16] + {2'd0, r_op[5:0]} + 8'd224,
                              r_prev[15:8] + {4'd0, b[3:0]} + {2'd0, r_op[5:0]} + 8'd216,
                              r_prev[7:0]};
                    end
                end
                S_FOOT: begin
                    flag = r_op[0];
                    if (b != ((r_pos[2:0] == 3'd7) ? 8'd1 : 8'd0)) flag = 1'b1;
                    if (r_pos[2:0] == 3'd7) begin
                        o_push = 1'b1;
                        o_cmd.count = RUN_W'(1);
                        if (flag) begin
                            o_cmd.status = ST_END_MARKER;
                        end else begin
                            o_cmd.status = ST_DONE;
                            o_cmd.width = r_w;
                            o_cmd.height = r_h;
                        end
                        n_state = S_FIN;
                        n_pos = '0;
                        n_op = '0;
                    end else begin
                        n_op = {7'd0, flag};
                        n_pos = {1'b0, r_pos[2:0] + 3'd1};
                    end
                end
                default: begin
                    // finished: drop bytes until stream end
                end
            endcase
        end else begin
            case (r_state)
                S_MUL: n_state = S_CHK;
                S_CHK: begin
                    if (!i_full) begin
                        if (r_w != 32'd0 && r_prod > {32'd0, i_max_pixels}) begin
                            o_push = 1'b1;
                            o_cmd.status = ST_TOO_LARGE;
                            o_cmd.count = RUN_W'(1);
                            n_state = S_FIN;
                            n_pos = '0;
                            n_op = '0;
                        end else begin
                            n_state = S_HDR;
                        end
                    end
                end
                S_IDX: begin
                    if (!i_full) begin
                        emit = 1'b1;
                        px = r_rvalid ? r_rdata : 32'd0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (emit) begin
            o_push = 1'b1;
            o_cmd = '0;
            o_cmd.pixel = px;
            o_cmd.status = ST_PIXEL;
            o_cmd.count = RUN_W'(1);
            n_prev = px;
            n_left = r_left - 32'd1;
            n_state = (r_left == 32'd1) ? S_FOOT : S_CHUNK;
            n_pos = '0;
            n_op = '0;
        end
    end

    assign we = emit;
    assign waddr = px_hash(px);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HDR;
            r_pos <= '0;
            r_op <= '0;
            r_w <= '0;
            r_h <= '0;
            r_left <= '0;
            r_prev <= PIXEL_START;
            r_tvalid <= '0;
        end else begin
            r_state <= n_state;
            r_pos <= n_pos;
            r_op <= n_op;
            r_w <= n_w;
            r_h <= n_h;
            r_left <= n_left;
            r_prev <= n_prev;
            if (tab_clear) r_tvalid <= '0;
            else if (we) r_tvalid[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= (r_state == S_MUL) ? 64'(r_w) * 64'(r_h) : r_prod;
        if (we) r_mem[waddr] <= px;
        r_rdata <= r_mem[raddr];
        r_rvalid <= r_tvalid[raddr];
    end

endmodule

@@ rtl/qoid_fifo.sv @@
// Two-entry queue of result groups between parser and output stage.
// Depends on qoid_pkg for t_cmd.
module qoid_fifo import qoid_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

@@ rtl/qoid_back.sv @@
// Output stage: plays each queued group out, repeating run pixels.
// Depends on qoid_pkg; drives the result channel of the top level.
module qoid_back import qoid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [2:0]  o_status,
    output logic        o_last_of_run,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height
);

    logic             r_valid;
    t_cmd             r_cmd;
    logic [RUN_W-1:0] r_left;
    logic             out_acc;
    logic             last;

    assign out_acc = r_valid && !i_stall;
    assign last = (r_left == RUN_W'(1));
    assign o_pop = !i_empty && (!r_valid || (out_acc && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_left <= i_head.count;
        end else if (out_acc) begin
            if (last) r_valid <= 1'b0;
            else r_left <= r_left - RUN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_head;
    end

    assign o_valid = r_valid;
    assign o_red = r_cmd.pixel[31:24];
    assign o_green = r_cmd.pixel[23:16];
    assign o_blue = r_cmd.pixel[15:8];
    assign o_alpha = r_cmd.pixel[7:0];
    assign o_status = r_cmd.status;
    assign o_last_of_run = last;
    assign o_image_width = r_cmd.width;
    assign o_image_height = r_cmd.height;

endmodule

@@ rtl/qoi_image_stream_decoder.sv @@
// Top level of the QOI stream decoder: config register, parser, queue, output stage.
// Depends on qoid_pkg, qoid_front, qoid_fifo and qoid_back.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_data_byte, i_stream_end
//   result    out        o_valid / i_stall   o_red..o_alpha, o_status, o_last_of_run, size
//   config    in         APB psel/penable    paddr, pwdata, prdata
//
// Header byte 11 is followed by the S_MUL and S_CHK states (width*height product
// and compare), an INDEX chunk by the S_IDX state for the seen-table memory read.
// A run chunk gives up to 62 results, one per cycle while not stalled; the two-entry
// queue lets the parser keep taking bytes while a run plays out, until the queue fills.
// Reset is synchronous, active low; the seen table is tracked by 64 valid bits,
// so no clearing pass is needed. i_stall holds the result registers.
module qoi_image_stream_decoder import qoid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [2:0]  o_status,
    output logic        o_last_of_run,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_max_pixels;
    logic        ready;
    logic        full;
    logic        empty;
    logic        push;
    logic        pop;
    t_cmd        cmd;
    t_cmd        head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? r_max_pixels : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pixels <= MAX_PIXELS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_max_pixels <= pwdata;
        end
    end

    assign o_stall = !ready;

    qoid_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .o_ready      (ready),
        .i_max_pixels (r_max_pixels),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    qoid_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    qoid_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_status       (o_status),
        .o_last_of_run  (o_last_of_run),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height)
    );

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_PIXEL |-> o_last_of_run)
        else $error("status result not marked last");

    a_size_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DONE |-> o_image_width == 32'd0 && o_image_height == 32'd0)
        else $error("image size on a non-done result");

    a_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_PIXEL |-> {o_red, o_green, o_blue, o_alpha} == 32'd0)
        else $error("pixel data on a status result");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("push into full queue");

endmodule

@@ dv/qoi_image_stream_decoder_test.sv @@
// Testbench for qoi_image_stream_decoder: feeds QOI byte streams and checks the decoded items.
// A built-in decoder predicts every result. Depends on qoid_pkg and the RTL.
module qoi_image_stream_decoder_test;
    import qoid_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam logic [2:0] REG_MAX_PIXELS = 3'd0;

    typedef enum logic [2:0] {
        PH_HEADER, PH_CHUNK, PH_OPERAND, PH_FOOTER, PH_FINISHED
    } t_decode_phase;

    typedef struct packed {
        logic [7:0]  red, green, blue, alpha;
        logic [2:0]  status;
        logic        last;
        logic [31:0] width, height;
    } t_decoded;

    class t_qoi_scoreboard;
        logic [31:0]   max_pixels;
        t_decode_phase phase;
        logic [3:0]    pos;
        logic [31:0]   width_q, height_q, remaining;
        logic [7:0]    opcode;
        logic [31:0]   prev_px;
        logic [31:0]   seen[TABLE_ENTRIES];
        t_decoded      expected_pixels[$];
        int            errors;

        function void reset_state();
            max_pixels = MAX_PIXELS_RESET;
            phase      = PH_HEADER;
            pos        = 0;
            width_q    = 0;
            height_q   = 0;
            remaining  = 0;
            opcode     = 0;
            prev_px    = 32'h0000_00FF;
            foreach (seen[i]) seen[i] = 0;
            errors     = 0;
        endfunction

        function int seen_slot(logic [31:0] px);
            int s;
            s = px[31:24] * 3 + px[23:16] * 5 + px[15:8] * 7 + px[7:0] * 11;
            return s % TABLE_ENTRIES;
        endfunction

        function void push(logic [31:0] px, logic [2:0] st, logic [31:0] wd, logic [31:0] ht,
                           logic last);
            t_decoded d;
            d.red = px[31:24]; d.green = px[23:16]; d.blue = px[15:8]; d.alpha = px[7:0];
            d.status = st; d.last = last; d.width = wd; d.height = ht;
            expected_pixels.insert(expected_pixels.size(), d);
        endfunction

        function void finish_with(logic [2:0] st, t_decode_phase nxt);
            push(0, st, 0, 0, 1);
            phase  = nxt;
            pos    = 0;
            opcode = 0;
        endfunction

        function void footer_if_done();
            if (remaining == 0) begin
                phase  = PH_FOOTER;
                pos    = 0;
                opcode = 0;
            end
        endfunction

        function void put_pixel();
            seen[seen_slot(prev_px)] = prev_px;
            push(prev_px, ST_PIXEL, 0, 0, 1);
            remaining--;
            phase = PH_CHUNK;
            pos   = 0;
            footer_if_done();
        endfunction

        function void note_input(logic [7:0] b, logic stream_end);
            logic [7:0]  magic[4];
            logic [31:0] n;
            logic [7:0]  nr, ng, nb;
            logic [5:0]  g6;
            int          sh, need;
            magic = '{8'h71, 8'h6F, 8'h69, 8'h66};
            if (stream_end) begin
                if (phase <= PH_FOOTER) finish_with(ST_ABRUPT, PH_HEADER);
                else begin
                    phase = PH_HEADER; pos = 0; opcode = 0;
                end
                return;
            end
            case (phase)
                PH_HEADER: begin
                    if (pos < 4) begin
                        if (pos == 0) opcode = 0;
                        if (b != magic[pos]) opcode = 1;
                        if (pos == 3 && opcode != 0) begin
                            finish_with(ST_MAGIC, PH_FINISHED);
                            return;
                        end
                    end else if (pos < 8) begin
                        width_q = {width_q[23:0], b};
                    end else if (pos < 12) begin
                        height_q = {height_q[23:0], b};
                        if (pos == 11 && width_q > 0 && height_q > max_pixels / width_q) begin
                            finish_with(ST_TOO_LARGE, PH_FINISHED);
                            return;
                        end
                    end else if (pos == 12) begin
                        if (b != 3 && b != 4) begin
                            finish_with(ST_CHANNELS, PH_FINISHED);
                            return;
                        end
                    end else begin
                        if (b > 1) begin
                            finish_with(ST_COLORSPACE, PH_FINISHED);
                            return;
                        end
                        prev_px = 32'h0000_00FF;
                        foreach (seen[i]) seen[i] = 0;
                        remaining = width_q * height_q;
                        phase = PH_CHUNK; pos = 0; opcode = 0;
                        footer_if_done();
                        return;
                    end
                    pos = pos + 1;
                end
                PH_CHUNK: begin
                    if (b == OP_RGB || b == OP_RGBA || b[7:6] == TAG_LUMA) begin
                        opcode = b; pos = 0; phase = PH_OPERAND;
                    end else if (b[7:6] == TAG_INDEX) begin
                        prev_px = seen[b[5:0]];
                        put_pixel();
                    end else if (b[7:6] == TAG_DIFF) begin
                        nr = prev_px[31:24] + b[5:4] + 8'd254;
                        ng = prev_px[23:16] + b[3:2] + 8'd254;
                        nb = prev_px[15:8] + b[1:0] + 8'd254;
                        prev_px = {nr, ng, nb, prev_px[7:0]};
                        put_pixel();
                    end else begin
                        n = b[5:0] + 1;
                        if (n > remaining) n = remaining;
                        for (int k = 0; k < n; k++) push(prev_px, ST_PIXEL, 0, 0, k == n - 1);
                        remaining -= n;
                        footer_if_done();
                    end
                end
                PH_OPERAND: begin
                    if (opcode == OP_RGB || opcode == OP_RGBA) begin
                        sh = 24 - 8 * pos[1:0];
                        prev_px[sh +: 8] = b;
                        need = (opcode == OP_RGB) ? 3 : 4;
                    end else begin
                        g6 = opcode[5:0];
                        nr = prev_px[31:24] + b[7:4] + g6 + 8'd216;
                        ng = prev_px[23:16] + g6 + 8'd224;
                        nb = prev_px[15:8] + b[3:0] + g6 + 8'd216;
                        prev_px = {nr, ng, nb, prev_px[7:0]};
                        need = 1;
                    end
                    pos = pos + 1;
                    if (pos >= need) put_pixel();
                end
                PH_FOOTER: begin
                    if (b != ((pos[2:0] == 7) ? 8'd1 : 8'd0)) opcode = 1;
                    if (pos[2:0] == 7) begin
                        if (opcode != 0) finish_with(ST_END_MARKER, PH_FINISHED);
                        else begin
                            push(0, ST_DONE, width_q, height_q, 1);
                            phase = PH_FINISHED; pos = 0; opcode = 0;
                        end
                        return;
                    end
                    pos = {1'b0, pos[2:0]} + 1;
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_decoded got);
            t_decoded exp_d;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result status=%0d rgba=%h%h%h%h", $realtime,
                         got.status, got.red, got.green, got.blue, got.alpha);
                errors++;
                return;
            end
            exp_d = expected_pixels.pop_front();
            if (exp_d != got) begin
                $display("%0t: mismatch expected rgba=%h%h%h%h st=%0d last=%0d w=%0d h=%0d",
                         $realtime, exp_d.red, exp_d.green, exp_d.blue, exp_d.alpha,
                         exp_d.status, exp_d.last, exp_d.width, exp_d.height);
                $display("%0t:          actual   rgba=%h%h%h%h st=%0d last=%0d w=%0d h=%0d",
                         $realtime, got.red, got.green, got.blue, got.alpha,
                         got.status, got.last, got.width, got.height);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic [7:0]  i_data_byte = 0;
    logic        i_stream_end = 0;
    logic        i_stall = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic        o_stall, o_valid, o_last_of_run, pready;
    logic [7:0]  o_red, o_green, o_blue, o_alpha;
    logic [2:0]  o_status;
    logic [31:0] o_image_width, o_image_height, prdata;

    qoi_image_stream_decoder u_top (.*);

    always #1 i_clk = ~i_clk;

    typedef struct {
        logic [7:0] b;
        logic       e;
    } t_stream_item;

    t_qoi_scoreboard      sb;
    t_stream_item         feed[$];
    int                   bytes_sent = 0;
    int                   quiet_cycles = 0;
    int                   hold_left = 0;
    bit                   calm = 0;
    bit                   pressure_req = 0;
    bit                   pressure_done = 0;

    // receiver: random stall, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1;
        end else if (pressure_req && !pressure_done) begin
            pressure_done <= 1;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1;
        end else begin
            i_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
        end
    end

    always @(posedge i_clk) begin
        t_decoded got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.red = o_red; got.green = o_green; got.blue = o_blue; got.alpha = o_alpha;
            got.status = o_status; got.last = o_last_of_run;
            got.width = o_image_width; got.height = o_image_height;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("qoi_image_stream_decoder_test: done, errors");
            $finish;
        end
    end

    task automatic add(logic [7:0] b, logic e = 0);
        t_stream_item it;
        it.b = b; it.e = e;
        feed.insert(feed.size(), it);
    endtask

    task automatic send_feed();
        while (feed.size() > 0) begin
            calm = (bytes_sent >= 180 && bytes_sent < 260);
            if (!calm && $urandom_range(99) < 36) begin
                i_valid <= 0;
                @(posedge i_clk);
            end else begin
                i_valid      <= 1;
                i_data_byte  <= feed[0].b;
                i_stream_end <= feed[0].e;
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
                sb.note_input(feed[0].b, feed[0].e);
                void'(feed.pop_front());
                bytes_sent++;
            end
        end
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic add_header(logic [31:0] w, logic [31:0] h, logic [7:0] ch, logic [7:0] cs,
                              int bad_magic);
        logic [7:0] magic[4];
        magic = '{8'h71, 8'h6F, 8'h69, 8'h66};
        for (int i = 0; i < 4; i++)
            add(i == bad_magic ? magic[i] ^ 8'($urandom_range(1, 255)) : magic[i]);
        for (int i = 3; i >= 0; i--) add(w[8*i +: 8]);
        for (int i = 3; i >= 0; i--) add(h[8*i +: 8]);
        add(ch);
        add(cs);
    endtask

    task automatic add_chunks(int npix);
        int rem, run;
        rem = npix;
        while (rem > 0) begin
            case ($urandom_range(0, 5))
                0: begin
                    add(OP_RGB);
                    repeat (3) add(8'($urandom_range(0, 255)));
                    rem--;
                end
                1: begin
                    add(OP_RGBA);
                    repeat (4) add(8'($urandom_range(0, 255)));
                    rem--;
                end
                2: begin add({TAG_INDEX, 6'($urandom_range(0, 63))}); rem--; end
                3: begin add({TAG_DIFF, 6'($urandom_range(0, 63))}); rem--; end
                4: begin
                    add({TAG_LUMA, 6'($urandom_range(0, 63))});
                    add(8'($urandom_range(0, 255)));
                    rem--;
                end
                default: begin
                    run = $urandom_range(0, 61);
                    add({TAG_RUN, 6'(run)});
                    rem -= (run + 1 > rem) ? rem : run + 1;
                end
            endcase
        end
    endtask

    task automatic add_footer(bit corrupt);
        int bad;
        bad = corrupt ? $urandom_range(0, 7) : -1;
        for (int i = 0; i < 8; i++) add((i == 7 ? 8'd1 : 8'd0) ^ (i == bad ? 8'h10 : 8'h00));
    endtask

    task automatic write_max_pixels(logic [31:0] v);
        while (sb.expected_pixels.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= REG_MAX_PIXELS; pwdata <= v; penable <= 0;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.max_pixels = v;
        @(posedge i_clk);
    endtask

    task automatic random_stream();
        int kind, w, h, cut;
        kind = $urandom_range(0, 99);
        w = $urandom_range(0, 5);
        h = $urandom_range(0, 5);
        if (kind < 60) begin
            add_header(w, h, 8'($urandom_range(3, 4)), 8'($urandom_range(0, 1)), -1);
            add_chunks(w * h);
            add_footer(0);
            if ($urandom_range(0, 3) == 0) add(8'($urandom_range(0, 255)));
        end else if (kind < 70) begin
            // drop the tail and end the stream mid-image
            add_header(w + 1, h + 1, 4, 0, -1);
            add_chunks((w + 1) * (h + 1));
            cut = $urandom_range(1, feed.size() - 1);
            while (feed.size() > cut) void'(feed.pop_back());
        end else if (kind < 77) begin
            add_header(w, h, 3, 0, $urandom_range(0, 3));
        end else if (kind < 84) begin
            if ($urandom_range(0, 2) == 0) add_header('1, '1, 3, 0, -1);
            else add_header($urandom, $urandom_range(0, 3) == 0 ? 0 : $urandom, 3, 0, -1);
        end else if (kind < 89) begin
            add_header(w, h, 8'($urandom_range(0, 255)), 0, -1);
        end else if (kind < 94) begin
            add_header(w, h, 4, 8'($urandom_range(0, 255)), -1);
        end else begin
            add_header(w, h, 3, 1, -1);
            add_chunks(w * h);
            add_footer(1);
        end
        add(0, 1);
        if ($urandom_range(0, 9) == 0) add(8'($urandom_range(0, 255)), 1);
        send_feed();
    endtask

    initial begin
        logic [31:0] max_settings[4];
        int          next_cfg;
        sb = new();
        sb.reset_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // every chunk kind in one 3x2 image, a run that overshoots, then an empty image
        add_header(3, 2, 4, 1, -1);
        add(OP_RGB); add(8'h00); add(8'hFF); add(8'h80);
        add(OP_RGBA); add(8'hFF); add(8'h00); add(8'h7F); add(8'h01);
        add({TAG_INDEX, 6'd0});
        add({TAG_DIFF, 6'h3F});
        add({TAG_LUMA, 6'h3F}); add(8'hF0);
        add({TAG_RUN, 6'd61});
        add_footer(0);
        add(0, 1);
        add_header(0, 32'hFFFF_FFFF, 3, 0, -1);
        add_footer(0);
        add(0, 1);
        send_feed();

        max_settings = '{32'd1, 32'hFFFF_FFFF, 32'd12, MAX_PIXELS_RESET};
        next_cfg = 0;
        while (bytes_sent < 430) begin
            if (bytes_sent > 100 * (next_cfg + 1) && next_cfg < 4) begin
                write_max_pixels(max_settings[next_cfg]);
                next_cfg++;
            end
            if (bytes_sent > 300 && !pressure_req) begin
                // long runs while the receiver holds off; the image must pass the size check
                write_max_pixels(MAX_PIXELS_RESET);
                pressure_req = 1;
                add_header(62, 1, 3, 0, -1);
                repeat (30) add({TAG_RUN, 6'd1});
                add({TAG_RUN, 6'd61});
                add_footer(0);
                add(0, 1);
                send_feed();
            end
            random_stream();
        end

        while (sb.expected_pixels.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_pixels.size() == 0)
            $display("qoi_image_stream_decoder_test: done, clean");
        else
            $display("qoi_image_stream_decoder_test: done, errors");
        $finish;
    end
endmodule
